### rtl/core/eeram_pkg.sv
// ---------------------------------------------------------------------------
// eeram_pkg: shared types and constants for the ZYX Euler to rotation matrix
// Fixed-point widths, CORDIC constants and the item structs.
// ---------------------------------------------------------------------------
`default_nettype none
package eeram_pkg;

   localparam int ANGLE_WIDTH = 16;
   localparam int ENTRY_WIDTH = 16;
   localparam int FRAC_Q      = 30;
   localparam int CORDIC_STEPS = 30;
   // angle scale to Q30
   localparam int ANGLE_SHIFT = FRAC_Q + 3 - ANGLE_WIDTH;
   localparam int ZW = 36;   // working angle width
   localparam int XW = 34;   // CORDIC x / y width
   localparam int TW = 32;   // sine / cosine width
   localparam int PW = 2 * TW;
   localparam int EF = ENTRY_WIDTH - 2;
   localparam int ROUND_SHIFT = FRAC_Q - EF;

   localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [XW-1:0] GAIN_INV    = 34'sd652032874;

   typedef struct packed {
      logic                          arm;
      logic signed [ANGLE_WIDTH-1:0] sensed_roll;
      logic signed [ANGLE_WIDTH-1:0] sensed_pitch;
      logic signed [ANGLE_WIDTH-1:0] sensed_yaw;
   } req_type;

   typedef struct packed {
      logic                          arm_tag;
      logic signed [ENTRY_WIDTH-1:0] m00;
      logic signed [ENTRY_WIDTH-1:0] m01;
      logic signed [ENTRY_WIDTH-1:0] m02;
      logic signed [ENTRY_WIDTH-1:0] m10;
      logic signed [ENTRY_WIDTH-1:0] m11;
      logic signed [ENTRY_WIDTH-1:0] m12;
      logic signed [ENTRY_WIDTH-1:0] m20;
      logic signed [ENTRY_WIDTH-1:0] m21;
      logic signed [ENTRY_WIDTH-1:0] m22;
   } rsp_type;

   // sine and cosine of the three angles, lane 0 = a, 1 = b, 2 = c
   typedef struct packed {
      logic                 valid;
      logic                 arm;
      logic [2:0][TW-1:0]   cosv;
      logic [2:0][TW-1:0]   sinv;
   } trig_type;

   // arctangent table in Q30; past step 9 it is 2^(30-i)
   function automatic logic signed [ZW-1:0] atan_entry(input int i);
      logic signed [ZW-1:0] t;
      case (i)
         0: t = 36'sd843314857;
         1: t = 36'sd497837829;
         2: t = 36'sd263043836;
         3: t = 36'sd133525159;
         4: t = 36'sd67021687;
         5: t = 36'sd33543516;
         6: t = 36'sd16775851;
         7: t = 36'sd8388437;
         8: t = 36'sd4194283;
         9: t = 36'sd2097149;
         default: t = ZW'(64'sd1 <<< (FRAC_Q - i));
      endcase
      return t;
   endfunction

   // Q30 product rounded back to Q30
   function automatic logic signed [TW-1:0] mulq(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
      logic signed [PW-1:0] p;
      p = (PW'(a) * PW'(b)) + (PW'(64'sd1) <<< (FRAC_Q - 1));
      p = p >>> FRAC_Q;
      return p[TW-1:0];
   endfunction

   // round Q30 to the entry format and clamp to +-1.0
   function automatic logic signed [ENTRY_WIDTH-1:0] entry_out(
      input logic signed [XW-1:0] v);
      logic signed [XW-1:0] r;
      logic signed [XW-1:0] one;
      one = XW'(64'sd1 <<< EF);
      if (ROUND_SHIFT > 0) begin
         r = (v + XW'(64'sd1 <<< ((ROUND_SHIFT > 0) ? ROUND_SHIFT - 1 : 0))) >>> ROUND_SHIFT;
      end else begin
         r = v;
      end
      if (r > one) begin
         r = one;
      end
      if (r < -one) begin
         r = -one;
      end
      return r[ENTRY_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

### rtl/core/eeram_sincos.sv
// ---------------------------------------------------------------------------
// eeram_sincos: pipelined CORDIC sine / cosine for three angles
// Negate and scale, range reduce, 30 rotation stages, then sign fix.
// ---------------------------------------------------------------------------
`default_nettype none
module eeram_sincos import eeram_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     enable,
   input  wire logic     in_valid,
   input  var  req_type  in_item,
   output var  trig_type out_trig
);

   logic [2:0][ANGLE_WIDTH-1:0] ang;
   logic [2:0][ZW-1:0]          z_red;
   logic [2:0]                  flip_red;

   logic [2:0][XW-1:0] x_ff [0:CORDIC_STEPS];
   logic [2:0][XW-1:0] y_ff [0:CORDIC_STEPS];
   logic [2:0][ZW-1:0] z_ff [0:CORDIC_STEPS];
   logic [2:0]         flip_ff [0:CORDIC_STEPS];
   logic               valid_ff [0:CORDIC_STEPS];
   logic               arm_ff [0:CORDIC_STEPS];

   trig_type out_ff;
   trig_type out_in;

   assign ang[0] = in_item.sensed_roll;
   assign ang[1] = in_item.sensed_pitch;
   assign ang[2] = in_item.sensed_yaw;

   // negate, scale to Q30 and fold into +-pi/2
   always_comb begin
      logic signed [ZW-1:0] z;
      for (int k = 0; k < 3; k++) begin
         z = -(ZW'($signed(ang[k])) <<< ANGLE_SHIFT);
         flip_red[k] = 1'b0;
         if (z > HALF_PI_Q30) begin
            z = z - PI_Q30;
            flip_red[k] = 1'b1;
         end else if (z < -HALF_PI_Q30) begin
            z = z + PI_Q30;
            flip_red[k] = 1'b1;
         end
         z_red[k] = z;
      end
   end

   // entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            x_ff[0][k] <= GAIN_INV;
            y_ff[0][k] <= '0;
         end
         z_ff[0]    <= z_red;
         flip_ff[0] <= flip_red;
         arm_ff[0]  <= in_item.arm;
      end
   end

   // one rotation per stage
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic [2:0][XW-1:0] x_in;
      logic [2:0][XW-1:0] y_in;
      logic [2:0][ZW-1:0] z_in;

      always_comb begin
         logic signed [XW-1:0] xs;
         logic signed [XW-1:0] ys;
         logic signed [ZW-1:0] zs;
         for (int k = 0; k < 3; k++) begin
            xs = $signed(x_ff[i][k]);
            ys = $signed(y_ff[i][k]);
            zs = $signed(z_ff[i][k]);
            if (zs >= 0) begin
               x_in[k] = xs - (ys >>> i);
               y_in[k] = ys + (xs >>> i);
               z_in[k] = zs - atan_entry(i);
            end else begin
               x_in[k] = xs + (ys >>> i);
               y_in[k] = ys - (xs >>> i);
               z_in[k] = zs + atan_entry(i);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            flip_ff[i+1] <= flip_ff[i];
            arm_ff[i+1]  <= arm_ff[i];
         end
      end
   end

   // apply the sign flip of the folded angles
   always_comb begin
      logic signed [XW-1:0] xf;
      logic signed [XW-1:0] yf;
      out_in.valid = valid_ff[CORDIC_STEPS];
      out_in.arm   = arm_ff[CORDIC_STEPS];
      for (int k = 0; k < 3; k++) begin
         xf = $signed(x_ff[CORDIC_STEPS][k]);
         yf = $signed(y_ff[CORDIC_STEPS][k]);
         if (flip_ff[CORDIC_STEPS][k]) begin
            xf = -xf;
            yf = -yf;
         end
         out_in.cosv[k] = xf[TW-1:0];
         out_in.sinv[k] = yf[TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (enable) begin
         out_ff.valid <= out_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff.arm  <= out_in.arm;
         out_ff.cosv <= out_in.cosv;
         out_ff.sinv <= out_in.sinv;
      end
   end

   assign out_trig = out_ff;

endmodule
`default_nettype wire

### rtl/core/eeram_matrix.sv
// ---------------------------------------------------------------------------
// eeram_matrix: products of sines and cosines into the nine matrix entries
// Two multiply stages, then sums, rounding and clamping into the output.
// ---------------------------------------------------------------------------
`default_nettype none
module eeram_matrix import eeram_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     enable,
   input  var  trig_type in_trig,
   output logic          out_valid,
   output var  rsp_type  out_item
);

   logic signed [TW-1:0] ca, sa, cb, sb, cc, sc;

   assign ca = $signed(in_trig.cosv[0]);
   assign sa = $signed(in_trig.sinv[0]);
   assign cb = $signed(in_trig.cosv[1]);
   assign sb = $signed(in_trig.sinv[1]);
   assign cc = $signed(in_trig.cosv[2]);
   assign sc = $signed(in_trig.sinv[2]);

   // first products
   logic                 a_valid_ff, a_arm_ff;
   logic signed [TW-1:0] casb_ff, sasb_ff, cacb_ff, sacc_ff, sasc_ff, cacc_ff;
   logic signed [TW-1:0] casc_ff, sacb_ff, cbsc_ff, cbcc_ff, a_sb_ff, a_cc_ff, a_sc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= in_trig.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_arm_ff <= in_trig.arm;
         casb_ff  <= mulq(ca, sb);
         sasb_ff  <= mulq(sa, sb);
         cacb_ff  <= mulq(ca, cb);
         sacc_ff  <= mulq(sa, cc);
         sasc_ff  <= mulq(sa, sc);
         cacc_ff  <= mulq(ca, cc);
         casc_ff  <= mulq(ca, sc);
         sacb_ff  <= mulq(sa, cb);
         cbsc_ff  <= mulq(cb, sc);
         cbcc_ff  <= mulq(cb, cc);
         a_sb_ff  <= sb;
         a_cc_ff  <= cc;
         a_sc_ff  <= sc;
      end
   end

   // three-factor terms
   logic                 b_valid_ff, b_arm_ff;
   logic signed [TW-1:0] t01_ff, t02_ff, t11_ff, t12_ff;
   logic signed [TW-1:0] b_cacb_ff, b_sacc_ff, b_sasc_ff, b_cacc_ff, b_casc_ff;
   logic signed [TW-1:0] b_sacb_ff, b_cbsc_ff, b_cbcc_ff, b_sb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         b_arm_ff  <= a_arm_ff;
         t01_ff    <= mulq(casb_ff, a_sc_ff);
         t02_ff    <= mulq(casb_ff, a_cc_ff);
         t11_ff    <= mulq(sasb_ff, a_sc_ff);
         t12_ff    <= mulq(sasb_ff, a_cc_ff);
         b_cacb_ff <= cacb_ff;
         b_sacc_ff <= sacc_ff;
         b_sasc_ff <= sasc_ff;
         b_cacc_ff <= cacc_ff;
         b_casc_ff <= casc_ff;
         b_sacb_ff <= sacb_ff;
         b_cbsc_ff <= cbsc_ff;
         b_cbcc_ff <= cbcc_ff;
         b_sb_ff   <= a_sb_ff;
      end
   end

   // sums, rounding and clamping
   rsp_type out_in;
   rsp_type out_ff;
   logic    valid_ff;

   always_comb begin
      out_in.arm_tag = b_arm_ff;
      out_in.m00 = entry_out(XW'(b_cacb_ff));
      out_in.m01 = entry_out(XW'(t01_ff) - XW'(b_sacc_ff));
      out_in.m02 = entry_out(XW'(t02_ff) + XW'(b_sasc_ff));
      out_in.m10 = entry_out(XW'(b_sacb_ff));
      out_in.m11 = entry_out(XW'(t11_ff) + XW'(b_cacc_ff));
      out_in.m12 = entry_out(XW'(t12_ff) - XW'(b_casc_ff));
      out_in.m20 = entry_out(-XW'(b_sb_ff));
      out_in.m21 = entry_out(XW'(b_cbsc_ff));
      out_in.m22 = entry_out(XW'(b_cbcc_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = out_ff;

endmodule
`default_nettype wire

### rtl/core/euler_angles_to_rotation_matrix.sv
// Pipeline: range reduction, 30 CORDIC stages, sign fix, two multiply stages
// and the output register lie between an accepted item and its result.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits on rsp_stall. Reset clears all valid bits; no item is in flight.
// ---------------------------------------------------------------------------
// euler_angles_to_rotation_matrix: ZYX Euler angles to rotation matrix
// Negated roll, pitch, yaw go through CORDIC and a product tree into Q2.14.
// ---------------------------------------------------------------------------
`default_nettype none
module euler_angles_to_rotation_matrix import eeram_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  var  req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output var  rsp_type rsp_data
);

   logic     enable;
   trig_type trig;

   // advance unless a finished item is held at the output
   assign enable    = !rsp_valid || !rsp_stall;
   assign req_stall = !enable;

   eeram_sincos u_sincos (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (req_valid),
      .in_item  (req_data),
      .out_trig (trig)
   );

   eeram_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_trig   (trig),
      .out_valid (rsp_valid),
      .out_item  (rsp_data)
   );

   localparam logic signed [ENTRY_WIDTH-1:0] ONE_E = ENTRY_WIDTH'(1 << EF);

   a_m00_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_data.m00) <= ONE_E && $signed(rsp_data.m00) >= -ONE_E))
      else $error("m00 out of range");

   a_m11_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_data.m11) <= ONE_E && $signed(rsp_data.m11) >= -ONE_E))
      else $error("m11 out of range");

   a_hold_out : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("held result changed");

endmodule
`default_nettype wire

### bench/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for euler_angles_to_rotation_matrix
// Drives angle items in bursts, predicts each matrix with a bit-exact CORDIC
// and product model, and checks every result item in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

import eeram_pkg::*;

// Expected matrices in order of acceptance; computes them from the angles.
class matrix_scoreboard;
   rsp_type pending[$];
   int      mismatches;

   // floor shift of a signed value
   static function longint floor_shr(longint x, int s);
      return x >>> s;
   endfunction

   static function longint round_q30(longint p);
      return (p + (64'sd1 <<< 29)) >>> 30;
   endfunction

   static function void sin_cos(longint z, output longint c, output longint s);
      longint x, y, t, dx, dy;
      bit flip;
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 64'sd1686629713) begin
         z = z - 64'sd3373259426;
         flip = 1;
      end else if (z < -64'sd1686629713) begin
         z = z + 64'sd3373259426;
         flip = 1;
      end
      for (int i = 0; i < 30; i++) begin
         case (i)
            0: t = 843314857;
            1: t = 497837829;
            2: t = 263043836;
            3: t = 133525159;
            4: t = 67021687;
            5: t = 33543516;
            6: t = 16775851;
            7: t = 8388437;
            8: t = 4194283;
            9: t = 2097149;
            default: t = 64'sd1 <<< (30 - i);
         endcase
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - t;
         end else begin
            x = x + dx; y = y - dy; z = z + t;
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = x;
      s = y;
   endfunction

   static function logic [15:0] to_entry(longint v);
      longint r;
      r = (v + (64'sd1 <<< 15)) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   // note an accepted input item
   function void note_angles(req_type q);
      longint ca, sa, cb, sb, cc, sc, casb, sasb;
      rsp_type e;
      sin_cos(-longint'(q.sensed_roll) * 131072, ca, sa);
      sin_cos(-longint'(q.sensed_pitch) * 131072, cb, sb);
      sin_cos(-longint'(q.sensed_yaw) * 131072, cc, sc);
      casb = round_q30(ca * sb);
      sasb = round_q30(sa * sb);
      e.arm_tag = q.arm;
      e.m00 = to_entry(round_q30(ca * cb));
      e.m01 = to_entry(round_q30(casb * sc) - round_q30(sa * cc));
      e.m02 = to_entry(round_q30(casb * cc) + round_q30(sa * sc));
      e.m10 = to_entry(round_q30(sa * cb));
      e.m11 = to_entry(round_q30(sasb * sc) + round_q30(ca * cc));
      e.m12 = to_entry(round_q30(sasb * cc) - round_q30(ca * sc));
      e.m20 = to_entry(-sb);
      e.m21 = to_entry(round_q30(cb * sc));
      e.m22 = to_entry(round_q30(cb * cc));
      pending.push_back(e);
   endfunction

   // check a result item against the oldest expectation
   function void check_matrix(rsp_type got);
      rsp_type e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result item %h", got);
         return;
      end
      e = pending.pop_front();
      if (got !== e) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch: expected tag %0d m %0d %0d %0d %0d %0d %0d %0d %0d %0d,",
                      " got tag %0d m %0d %0d %0d %0d %0d %0d %0d %0d %0d"},
               e.arm_tag, e.m00, e.m01, e.m02, e.m10, e.m11, e.m12, e.m20, e.m21, e.m22,
               got.arm_tag, got.m00, got.m01, got.m02, got.m10, got.m11, got.m12,
               got.m20, got.m21, got.m22);
      end
   endfunction
endclass

module tb;
   localparam int NUM_RANDOM = 1880;
   localparam int IDLE_LIMIT = 20000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   matrix_scoreboard board = new();
   bit      sending_done = 0;
   bit      hold_off = 0;
   int      idle_cycles = 0;

   euler_angles_to_rotation_matrix DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // offer one item and hold it until it is accepted
   task automatic send_angles(logic arm, logic [15:0] r, logic [15:0] p, logic [15:0] y);
      req_data <= '{arm, r, p, y};
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      board.note_angles(req_data);
   endtask

   task automatic drop_valid(int gap);
      req_valid <= 0;
      repeat (gap) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 9))
         0: return 16'(25736);
         1: return -16'(25736);
         2: return 16'($urandom_range(0, 32767));   // past the stated range
         3: return 16'h8000 | 16'($urandom());
         4: return 16'($signed($urandom_range(0, 400)) - 200);
         default: return 16'($signed($urandom_range(0, 51472)) - 25736);
      endcase
   endfunction

   // sender: directed corners, then random bursts
   initial begin
      logic [15:0] corners[8];
      int burst;
      corners = '{16'h0000, 16'(25736), -16'(25736), 16'h7fff, 16'h8000,
                  16'(12868), -16'(12868), 16'h0001};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 8; i++) send_angles(i[0], corners[i], 16'h0000, 16'h0000);
      for (int i = 0; i < 8; i++) send_angles(~i[0], 16'h0000, corners[i], 16'h0000);
      for (int i = 0; i < 8; i++) send_angles(i[1], 16'h0000, 16'h0000, corners[i]);
      drop_valid(3);
      for (int n = 0; n < NUM_RANDOM;) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++)
            send_angles(1'($urandom_range(0, 1)), rand_angle(), rand_angle(), rand_angle());
         if ($urandom_range(0, 2) != 0) drop_valid($urandom_range(1, 8));
      end
      req_valid <= 0;
      sending_done = 1;
   end

   // receiver: random stall pattern plus one long hold-off
   initial begin
      repeat (300) @(posedge clock);
      hold_off <= 1;
      repeat (200) @(posedge clock);
      hold_off <= 0;
   end

   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1;
      else if ($urandom_range(0, 99) < 60) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // check results and watch for a hang
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_matrix(rsp_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      wait (sending_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

### sim.f
rtl/core/eeram_pkg.sv
rtl/core/eeram_sincos.sv
rtl/core/eeram_matrix.sv
rtl/core/euler_angles_to_rotation_matrix.sv
bench/tb.sv
